// ----- sv/hrhp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the HTTP response head parser.
// Holds the line length limit, the event codes, the character codes and the result type.
// Depends on nothing.
package hrhp_pkg;

    localparam int MAX_LINE_LEN = 1024;
    localparam int OFF_W        = $clog2(MAX_LINE_LEN + 1);
    localparam int REP_W        = 10;
    localparam int CODE_W       = 10;

    localparam logic [2:0] EV_MORE   = 3'd0;
    localparam logic [2:0] EV_STATUS = 3'd1;
    localparam logic [2:0] EV_HEADER = 3'd2;
    localparam logic [2:0] EV_END    = 3'd3;
    localparam logic [2:0] EV_ERROR  = 3'd4;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef struct packed {
        logic [2:0]        event_res;
        logic [CODE_W-1:0] status_code;
        logic [REP_W-1:0]  name_end;
        logic [REP_W-1:0]  value_begin;
        logic [REP_W-1:0]  value_finish;
    } result_t;

endpackage

// ----- sv/http_response_head_parser.sv -----
`timescale 1ns / 1ps
// HTTP response head parser: status line check and header line offsets, one byte per beat.
// Depends on hrhp_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / byte_req) takes one raw byte of the response
//   head per beat. Output channel (out_valid / out_stall / event_res ...) gives exactly
//   one result beat per input beat, in order.
//   event_res: 0 need more, 1 status line done (status_code valid), 2 header line done
//   (name_end / value_begin / value_finish valid, offsets within the line), 3 head end,
//   4 error. Fields not tied to the reported event read zero.
//   The result of a byte is registered in the result register, or in the skid register.
//   Throughput: one byte per cycle while in_stall is low; the parse state registers are
//   updated from the byte in the same cycle it is accepted.
//   Stalls: a two-entry output (result register plus skid register) lets one more byte in
//   while a result waits; in_stall rises only when both entries are full.
//   Errors are sticky: every later byte answers 4 until reset. A line of MAX_LINE_LEN bytes
//   without a line end is an error.
//   Reset (rst_n low, asynchronous) returns to the status line phase, clears the line
//   offset and empties both output entries.
module http_response_head_parser
    import hrhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        byte_req,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        event_res,
    output logic [CODE_W-1:0] status_code,
    output logic [REP_W-1:0]  name_end,
    output logic [REP_W-1:0]  value_begin,
    output logic [REP_W-1:0]  value_finish
);

    localparam logic [1:0] PH_STATUS = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_ERROR  = 2'd2;

    // status line states
    localparam logic [3:0] S_START = 4'd0;
    localparam logic [3:0] S_H     = 4'd1;
    localparam logic [3:0] S_HT    = 4'd2;
    localparam logic [3:0] S_HTT   = 4'd3;
    localparam logic [3:0] S_HTTP  = 4'd4;
    localparam logic [3:0] S_MAJ1  = 4'd5;
    localparam logic [3:0] S_MAJ   = 4'd6;
    localparam logic [3:0] S_MIN1  = 4'd7;
    localparam logic [3:0] S_MIN   = 4'd8;
    localparam logic [3:0] S_C1    = 4'd9;
    localparam logic [3:0] S_C2    = 4'd10;
    localparam logic [3:0] S_C3    = 4'd11;
    localparam logic [3:0] S_SP    = 4'd12;
    localparam logic [3:0] S_TEXT  = 4'd13;
    localparam logic [3:0] S_CR    = 4'd14;

    // header line states
    localparam logic [3:0] H_START = 4'd0;
    localparam logic [3:0] H_NAME  = 4'd1;
    localparam logic [3:0] H_SPB   = 4'd2;
    localparam logic [3:0] H_VAL   = 4'd3;
    localparam logic [3:0] H_SPA   = 4'd4;
    localparam logic [3:0] H_CR    = 4'd5;
    localparam logic [3:0] H_ENDCR = 4'd6;

    logic [1:0]        phase_reg, phase_next;
    logic [3:0]        state_reg, state_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [OFF_W-1:0]  offset_reg, offset_next;
    logic [REP_W-1:0]  name_end_reg, name_end_next;
    logic [REP_W-1:0]  value_begin_reg, value_begin_next;
    logic [REP_W-1:0]  value_finish_reg, value_finish_next;

    logic              out_valid_reg;
    logic              skid_valid_reg;
    result_t           out_reg;
    result_t           skid_reg;
    result_t           res;

    logic              in_accept;
    logic              out_take;
    logic [2:0]        ev;
    logic [3:0]        st;
    logic [REP_W-1:0]  off;
    logic              is_digit;
    logic [13:0]       code_mac;

    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;

    assign off      = REP_W'(offset_reg);
    assign is_digit = (byte_req >= CH_0) && (byte_req <= CH_9);
    assign code_mac = 14'(code_reg) * 14'd10 + 14'(byte_req[3:0]);

    // parse one byte
    always_comb
    begin
        ev                = EV_MORE;
        st                = state_reg;
        code_next         = code_reg;
        name_end_next     = name_end_reg;
        value_begin_next  = value_begin_reg;
        value_finish_next = value_finish_reg;

        if (phase_reg != PH_STATUS && phase_reg != PH_HEADER) begin
            ev = EV_ERROR;
        end else if (offset_reg >= OFF_W'(MAX_LINE_LEN)) begin
            ev = EV_ERROR;
        end else if (phase_reg == PH_STATUS) begin
            unique case (state_reg)
                S_START: if (byte_req == CH_H) st = S_H; else ev = EV_ERROR;
                S_H:     if (byte_req == CH_T) st = S_HT; else ev = EV_ERROR;
                S_HT:    if (byte_req == CH_T) st = S_HTT; else ev = EV_ERROR;
                S_HTT:   if (byte_req == CH_P) st = S_HTTP; else ev = EV_ERROR;
                S_HTTP:  if (byte_req == CH_SLASH) st = S_MAJ1; else ev = EV_ERROR;
                S_MAJ1:
                begin
                    if (byte_req >= CH_1 && byte_req <= CH_9) st = S_MAJ;
                    else ev = EV_ERROR;
                end
                S_MAJ:
                begin
                    if (byte_req == CH_DOT) st = S_MIN1;
                    else if (!is_digit) ev = EV_ERROR;
                end
                S_MIN1:  if (is_digit) st = S_MIN; else ev = EV_ERROR;
                S_MIN:
                begin
                    if (byte_req == CH_SPACE) st = S_C1;
                    else if (!is_digit) ev = EV_ERROR;
                end
                S_C1:
                begin
                    if (is_digit) begin
                        code_next = CODE_W'(byte_req[3:0]);
                        st        = S_C2;
                    end else begin
                        ev = EV_ERROR;
                    end
                end
                S_C2, S_C3:
                begin
                    if (is_digit) begin
                        code_next = code_mac[CODE_W-1:0];
                        st        = (state_reg == S_C2) ? S_C3 : S_SP;
                    end else begin
                        ev = EV_ERROR;
                    end
                end
                S_SP:
                begin
                    if (byte_req == CH_SPACE) st = S_TEXT;
                    else if (byte_req == CH_CR) st = S_CR;
                    else if (byte_req == CH_LF) ev = EV_STATUS;
                    else ev = EV_ERROR;
                end
                S_TEXT:
                begin
                    if (byte_req == CH_CR) st = S_CR;
                    else if (byte_req == CH_LF) ev = EV_STATUS;
                end
                S_CR:    ev = (byte_req == CH_LF) ? EV_STATUS : EV_ERROR;
                default: ev = EV_ERROR;
            endcase
        end else begin
            unique case (state_reg)
                H_START:
                begin
                    if (byte_req == CH_CR) begin
                        name_end_next = off;
                        st            = H_ENDCR;
                    end else if (byte_req == CH_LF) begin
                        ev = EV_END;
                    end else begin
                        // first byte always opens the name, colon included
                        st = H_NAME;
                    end
                end
                H_NAME:
                begin
                    if (byte_req == CH_COLON) begin
                        name_end_next = off;
                        st            = H_SPB;
                    end else if (byte_req == CH_CR || byte_req == CH_LF) begin
                        name_end_next     = off;
                        value_begin_next  = off;
                        value_finish_next = off;
                        if (byte_req == CH_LF) ev = EV_HEADER;
                        else st = H_CR;
                    end
                end
                H_SPB:
                begin
                    if (byte_req == CH_CR || byte_req == CH_LF) begin
                        value_begin_next  = off;
                        value_finish_next = off;
                        if (byte_req == CH_LF) ev = EV_HEADER;
                        else st = H_CR;
                    end else if (byte_req != CH_SPACE) begin
                        value_begin_next = off;
                        st               = H_VAL;
                    end
                end
                H_VAL:
                begin
                    if (byte_req == CH_SPACE) begin
                        value_finish_next = off;
                        st                = H_SPA;
                    end else if (byte_req == CH_CR) begin
                        value_finish_next = off;
                        st                = H_CR;
                    end else if (byte_req == CH_LF) begin
                        value_finish_next = off;
                        ev                = EV_HEADER;
                    end
                end
                H_SPA:
                begin
                    if (byte_req == CH_CR) st = H_CR;
                    else if (byte_req == CH_LF) ev = EV_HEADER;
                    else if (byte_req != CH_SPACE) st = H_VAL;
                end
                H_CR:
                begin
                    // extra CRs before the LF are dropped
                    if (byte_req == CH_LF) ev = EV_HEADER;
                    else if (byte_req != CH_CR) ev = EV_ERROR;
                end
                H_ENDCR: ev = (byte_req == CH_LF) ? EV_END : EV_ERROR;
                default: ev = EV_ERROR;
            endcase
        end
    end

    // commit on event, build result
    always_comb
    begin
        phase_next  = phase_reg;
        state_next  = st;
        offset_next = offset_reg;

        res              = '0;
        res.event_res    = ev;

        case (ev)
            EV_MORE:   offset_next = offset_reg + 1'b1;
            EV_STATUS:
            begin
                res.status_code = code_reg;
                phase_next      = PH_HEADER;
                state_next      = S_START;
                offset_next     = '0;
            end
            EV_HEADER:
            begin
                res.name_end     = name_end_next;
                res.value_begin  = value_begin_next;
                res.value_finish = value_finish_next;
                state_next       = H_START;
                offset_next      = '0;
            end
            EV_END:
            begin
                phase_next  = PH_STATUS;
                state_next  = S_START;
                offset_next = '0;
            end
            default:
            begin
                phase_next = PH_ERROR;
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PH_STATUS;
            state_reg        <= S_START;
            code_reg         <= '0;
            offset_reg       <= '0;
            name_end_reg     <= '0;
            value_begin_reg  <= '0;
            value_finish_reg <= '0;
        end else if (in_accept) begin
            phase_reg        <= phase_next;
            state_reg        <= state_next;
            code_reg         <= code_next;
            offset_reg       <= offset_next;
            name_end_reg     <= name_end_next;
            value_begin_reg  <= value_begin_next;
            value_finish_reg <= value_finish_next;
        end
    end

    // two-entry output: result register with a skid register behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_accept;
            end
        end else if (in_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) out_reg <= skid_reg;
            else if (in_accept) out_reg <= res;
        end else if (in_accept) begin
            skid_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = out_reg.event_res;
    assign status_code  = out_reg.status_code;
    assign name_end     = out_reg.name_end;
    assign value_begin  = out_reg.value_begin;
    assign value_finish = out_reg.value_finish;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while result register empty");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR && in_accept) |=> phase_reg == PH_ERROR)
        else $error("left error phase without reset");

    a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= OFF_W'(MAX_LINE_LEN))
        else $error("line offset past limit");

    a_code_only_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.event_res != EV_STATUS) |-> out_reg.status_code == '0)
        else $error("status code on a non-status beat");
`endif

endmodule

// ----- sim/http_response_head_parser_tb.sv -----
`timescale 1ns / 1ps
// Testbench for http_response_head_parser: well-formed response heads with random content,
// a directed head, and a single sticky error at the end, checked beat by beat.
// Depends on hrhp_pkg and http_response_head_parser.
module http_response_head_parser_tb;
    import hrhp_pkg::*;

    typedef enum logic [1:0] {IN_STATUS, IN_HEADERS, IN_ERROR} parse_phase_t;

    typedef enum logic [3:0] {
        SL_START, SL_H, SL_HT, SL_HTT, SL_HTTP, SL_MAJ1, SL_MAJ, SL_MIN1, SL_MIN,
        SL_C1, SL_C2, SL_C3, SL_SP, SL_TEXT, SL_CR
    } status_pos_t;

    typedef enum logic [2:0] {
        HL_START, HL_NAME, HL_SPB, HL_VAL, HL_SPA, HL_CR, HL_ENDCR
    } header_pos_t;

    // ways to break the stream once the random heads are done
    typedef enum int {
        F_BAD_STATUS, F_LONG_LINE, F_EMPTY_CR, F_HEADER_CR, F_STATUS_CR, F_MAJOR_ZERO
    } fault_t;

    class head_parse_checker;
        result_t      expected_events[$];
        int unsigned  mismatches;
        int unsigned  checked;
        parse_phase_t phase;
        status_pos_t  sl;
        header_pos_t  hl;
        int unsigned  code;
        int unsigned  offset;
        int unsigned  nm_end;
        int unsigned  val_beg;
        int unsigned  val_fin;

        function new();
            mismatches = 0;
            checked    = 0;
            phase      = IN_STATUS;
            sl         = SL_START;
            hl         = HL_START;
            code       = 0;
            offset     = 0;
            nm_end     = 0;
            val_beg    = 0;
            val_fin    = 0;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t beat %0d: %s", $realtime, checked, what);
        endtask

        function void note_byte(logic [7:0] c);
            logic [2:0] ev;
            result_t    want;
            ev   = EV_MORE;
            want = '0;
            if (phase != IN_STATUS && phase != IN_HEADERS)
                ev = EV_ERROR;
            else if (offset >= MAX_LINE_LEN)
                ev = EV_ERROR;
            else if (phase == IN_STATUS)
            begin
                case (sl)
                    SL_START: if (c == CH_H) sl = SL_H; else ev = EV_ERROR;
                    SL_H:     if (c == CH_T) sl = SL_HT; else ev = EV_ERROR;
                    SL_HT:    if (c == CH_T) sl = SL_HTT; else ev = EV_ERROR;
                    SL_HTT:   if (c == CH_P) sl = SL_HTTP; else ev = EV_ERROR;
                    SL_HTTP:  if (c == CH_SLASH) sl = SL_MAJ1; else ev = EV_ERROR;
                    SL_MAJ1:  if (c >= CH_1 && c <= CH_9) sl = SL_MAJ; else ev = EV_ERROR;
                    SL_MAJ:
                        if (c == CH_DOT) sl = SL_MIN1;
                        else if (!is_num(c)) ev = EV_ERROR;
                    SL_MIN1:  if (is_num(c)) sl = SL_MIN; else ev = EV_ERROR;
                    SL_MIN:
                        if (c == CH_SPACE) sl = SL_C1;
                        else if (!is_num(c)) ev = EV_ERROR;
                    SL_C1, SL_C2, SL_C3:
                        if (!is_num(c))
                            ev = EV_ERROR;
                        else
                        begin
                            code = ((sl == SL_C1) ? 0 : code * 10) + int'(c - CH_0);
                            code = code % 1024;
                            if (sl == SL_C1) sl = SL_C2;
                            else if (sl == SL_C2) sl = SL_C3;
                            else sl = SL_SP;
                        end
                    SL_SP:
                        if (c == CH_SPACE) sl = SL_TEXT;
                        else if (c == CH_CR) sl = SL_CR;
                        else if (c == CH_LF) ev = EV_STATUS;
                        else ev = EV_ERROR;
                    SL_TEXT:
                        if (c == CH_CR) sl = SL_CR;
                        else if (c == CH_LF) ev = EV_STATUS;
                    SL_CR:    ev = (c == CH_LF) ? EV_STATUS : EV_ERROR;
                    default:  ev = EV_ERROR;
                endcase
            end
            else
            begin
                case (hl)
                    // first byte always opens the name, colon or not
                    HL_START:
                        if (c == CH_CR)
                        begin
                            nm_end = offset;
                            hl     = HL_ENDCR;
                        end
                        else if (c == CH_LF) ev = EV_END;
                        else hl = HL_NAME;
                    HL_NAME:
                        if (c == CH_COLON)
                        begin
                            nm_end = offset;
                            hl     = HL_SPB;
                        end
                        else if (c == CH_CR || c == CH_LF)
                        begin
                            nm_end  = offset;
                            val_beg = offset;
                            val_fin = offset;
                            if (c == CH_LF) ev = EV_HEADER; else hl = HL_CR;
                        end
                    HL_SPB:
                        if (c == CH_CR || c == CH_LF)
                        begin
                            val_beg = offset;
                            val_fin = offset;
                            if (c == CH_LF) ev = EV_HEADER; else hl = HL_CR;
                        end
                        else if (c != CH_SPACE)
                        begin
                            val_beg = offset;
                            hl      = HL_VAL;
                        end
                    HL_VAL:
                        if (c == CH_SPACE || c == CH_CR || c == CH_LF)
                        begin
                            val_fin = offset;
                            if (c == CH_SPACE) hl = HL_SPA;
                            else if (c == CH_CR) hl = HL_CR;
                            else ev = EV_HEADER;
                        end
                    // inner spaces stay in the value; finish only moves on a new word end
                    HL_SPA:
                        if (c == CH_CR) hl = HL_CR;
                        else if (c == CH_LF) ev = EV_HEADER;
                        else if (c != CH_SPACE) hl = HL_VAL;
                    HL_CR:
                        if (c == CH_LF) ev = EV_HEADER;
                        else if (c != CH_CR) ev = EV_ERROR;
                    HL_ENDCR: ev = (c == CH_LF) ? EV_END : EV_ERROR;
                    default:  ev = EV_ERROR;
                endcase
            end

            case (ev)
                EV_MORE:
                    offset++;
                EV_STATUS:
                begin
                    want.status_code = CODE_W'(code);
                    phase  = IN_HEADERS;
                    sl     = SL_START;
                    hl     = HL_START;
                    offset = 0;
                end
                EV_HEADER:
                begin
                    want.name_end     = REP_W'(nm_end);
                    want.value_begin  = REP_W'(val_beg);
                    want.value_finish = REP_W'(val_fin);
                    hl     = HL_START;
                    offset = 0;
                end
                EV_END:
                begin
                    phase  = IN_STATUS;
                    sl     = SL_START;
                    hl     = HL_START;
                    offset = 0;
                end
                default:
                    phase = IN_ERROR;
            endcase
            want.event_res = ev;
            expected_events.push_back(want);
        endfunction

        task check_event(result_t got);
            result_t want;
            checked++;
            if (expected_events.size() == 0)
            begin
                report_mismatch($sformatf("result with no byte waiting, event_res %0d",
                                          got.event_res));
                return;
            end
            want = expected_events.pop_front();
            if (got.event_res != want.event_res)
                report_mismatch($sformatf("event_res got %0d want %0d",
                                          got.event_res, want.event_res));
            if (got.status_code != want.status_code)
                report_mismatch($sformatf("status_code got %0d want %0d",
                                          got.status_code, want.status_code));
            if (got.name_end != want.name_end)
                report_mismatch($sformatf("name_end got %0d want %0d",
                                          got.name_end, want.name_end));
            if (got.value_begin != want.value_begin)
                report_mismatch($sformatf("value_begin got %0d want %0d",
                                          got.value_begin, want.value_begin));
            if (got.value_finish != want.value_finish)
                report_mismatch($sformatf("value_finish got %0d want %0d",
                                          got.value_finish, want.value_finish));
        endtask
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [7:0]        byte_req     = 8'h00;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [2:0]        event_res;
    logic [CODE_W-1:0] status_code;
    logic [REP_W-1:0]  name_end;
    logic [REP_W-1:0]  value_begin;
    logic [REP_W-1:0]  value_finish;

    head_parse_checker checker_h = new();
    int unsigned       bytes_sent = 0;
    bit                no_gaps    = 1'b0;
    bit                long_sent  = 1'b0;
    string             good_status = "HTTP/1.1 200";

    http_response_head_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_req     (byte_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .status_code  (status_code),
        .name_end     (name_end),
        .value_begin  (value_begin),
        .value_finish (value_finish)
    );

    always #2 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("http_response_head_parser_tb: FAIL");
        $finish;
    end

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(0, 99) < 26);
    endfunction

    // any byte that cannot end a line, and no space if no_space is set
    function automatic logic [7:0] text_byte(bit no_space);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF || (no_space && b == CH_SPACE));
        return b;
    endfunction

    always @(negedge clk)
        out_stall <= take_gap();

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            checker_h.check_event({event_res, status_code, name_end, value_begin,
                                   value_finish});
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        no_gaps = (bytes_sent >= 300 && bytes_sent < 700);
        while (take_gap())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        byte_req <= b;
        bytes_sent++;
        do
            @(posedge clk);
        while (in_stall);
        checker_h.note_byte(b);
        @(negedge clk);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_eol(input bit stray_ok);
        int kind;
        kind = $urandom_range(0, stray_ok ? 3 : 2);
        if (kind != 0)
            send_byte(CH_CR);
        if (kind == 3)
            repeat ($urandom_range(1, 3)) send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_header_line();
        int r;
        send_byte(text_byte(1'b0));
        repeat ($urandom_range(0, 11))
        begin
            r = $urandom_range(0, 9);
            if (r < 2) send_byte(CH_COLON);
            else if (r < 4) send_byte(CH_SPACE);
            else send_byte(text_byte(1'b0));
        end
        send_eol(1'b1);
    endtask

    task automatic send_random_head();
        int code;
        int r;
        send_str("HTTP/");
        send_byte(8'(CH_1 + $urandom_range(0, 8)));
        repeat ($urandom_range(0, 2)) send_byte(8'(CH_0 + $urandom_range(0, 9)));
        send_byte(CH_DOT);
        repeat ($urandom_range(1, 3)) send_byte(8'(CH_0 + $urandom_range(0, 9)));
        send_byte(CH_SPACE);
        r = $urandom_range(0, 5);
        code = (r == 0) ? 0 : (r == 1) ? 999 : $urandom_range(0, 999);
        send_byte(8'(CH_0 + code / 100));
        send_byte(8'(CH_0 + (code / 10) % 10));
        send_byte(8'(CH_0 + code % 10));
        if ($urandom_range(0, 1) != 0)
        begin
            send_byte(CH_SPACE);
            repeat ($urandom_range(0, 12)) send_byte(text_byte(1'b0));
        end
        send_eol(1'b0);
        repeat ($urandom_range(0, 6)) send_header_line();
        // one header of the longest legal length: value ends right at offset 1023
        if (!long_sent && bytes_sent >= 1000)
        begin
            long_sent = 1'b1;
            send_byte(text_byte(1'b0));
            send_byte(CH_COLON);
            repeat (MAX_LINE_LEN - 3) send_byte(text_byte(1'b1));
            send_byte(CH_LF);
        end
        send_eol(1'b0);
    endtask

    initial
    begin
        fault_t fault;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // status code zero, bare LF, colon-led name with no separator, stray CRs
        send_str("HTTP/1.0 000");
        send_byte(CH_LF);
        send_str(":x ");
        send_byte(CH_CR);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_LF);

        while (bytes_sent < 2000)
            send_random_head();

        // errors are sticky, so only one kind can be hit per run
        fault = fault_t'($urandom_range(0, 5));
        case (fault)
            F_BAD_STATUS:
            begin
                for (int i = 0; i < $urandom_range(0, 11); i++)
                    send_byte(good_status[i]);
                send_byte(8'($urandom_range(0, 255)));
            end
            F_LONG_LINE:
            begin
                send_str(good_status);
                send_byte(CH_CR);
                send_byte(CH_LF);
                repeat (MAX_LINE_LEN + 1) send_byte(text_byte(1'b0));
            end
            F_EMPTY_CR:
            begin
                send_str(good_status);
                send_byte(CH_CR);
                send_byte(CH_LF);
                send_byte(CH_CR);
                send_byte(text_byte(1'b0));
            end
            F_HEADER_CR:
            begin
                send_str(good_status);
                send_byte(CH_CR);
                send_byte(CH_LF);
                send_byte(text_byte(1'b0));
                send_byte(CH_CR);
                send_byte(text_byte(1'b0));
            end
            F_STATUS_CR:
            begin
                send_str(good_status);
                send_byte(CH_CR);
                send_byte(text_byte(1'b0));
            end
            default:
                send_str("HTTP/0");
        endcase
        repeat (8) send_byte(8'($urandom_range(0, 255)));
        in_valid <= 1'b0;

        while (checker_h.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (checker_h.mismatches == 0 && checker_h.pending() == 0)
            $display("http_response_head_parser_tb: PASS");
        else
            $display("http_response_head_parser_tb: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/hrhp_pkg.sv
sv/http_response_head_parser.sv
sim/http_response_head_parser_tb.sv
